### rtl/core/rfa_pkg.sv
package rfa_pkg;

    // fixed field widths of the request and result channels
    localparam int COORD_W = 22;
    localparam int TAG_W   = 16;
    localparam int FIT_W   = 33;
    localparam int DIMS_W  = 7;

    // largest fitness, sum saturates here
    localparam logic [FIT_W-1:0] SUM_MAX = '1;

    // pi/2 and one in Q30 for the table build
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // one coordinate request
    typedef struct packed {
        logic signed [COORD_W-1:0] coord_value;
        logic [TAG_W-1:0]          member_tag;
        logic                      last_coord;
    } t_in_req;

    // one fitness result request
    typedef struct packed {
        logic [FIT_W-1:0]  fitness;
        logic [TAG_W-1:0]  result_tag;
        logic [DIMS_W-1:0] dims_used;
        logic              saturated;
    } t_out_req;

    // unsigned quotient by shift and subtract, one quotient bit per step
    function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave cosine entry k, taylor series in Q30 rounded to frac_bits
    function automatic longint unsigned cos_entry(int k, int table_bits, int frac_bits);
        longint unsigned kk;
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned div;
        longint unsigned half;
        longint          acc;
        int              n;
        kk    = 64'(k);
        theta = (HALF_PI_Q30 * kk) >> table_bits;
        t2    = (theta * theta) >> 30;
        term  = ONE_Q30;
        acc   = longint'(ONE_Q30);
        for (n = 1; n <= 12; n++) begin
            term = (term * t2) >> 30;
            div  = 64'((2 * n - 1) * (2 * n));
            term = udiv_u64(term, div);
            if (n[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30)) begin
            acc = longint'(ONE_Q30);
        end
        half = 64'd1 << (30 - frac_bits - 1);
        return (longint'(acc) + half) >> (30 - frac_bits);
    endfunction

endpackage

### rtl/core/rfa_ram.sv
module rfa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/rfa_cos_lookup.sv
module rfa_cos_lookup #(
    parameter int FRAC_BITS  = 16,
    parameter int TABLE_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic signed [rfa_pkg::COORD_W-1:0] i_coord,
    output logic                               o_busy,
    output logic [FRAC_BITS+1:0]               o_gap
);

    localparam int N   = 1 << TABLE_BITS;
    localparam int P_W = TABLE_BITS + 2;
    localparam int E_W = FRAC_BITS + 1;
    localparam int G_W = FRAC_BITS + 2;
    localparam int X_W = FRAC_BITS + rfa_pkg::COORD_W;

    typedef logic [E_W-1:0] t_cos_rom [N];

    function automatic t_cos_rom build_rom();
        t_cos_rom rom;
        for (int k = 0; k < N; k++) begin
            rom[k] = E_W'(rfa_pkg::cos_entry(k, TABLE_BITS, FRAC_BITS));
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_rom();
    localparam logic [G_W-1:0] ONE = G_W'(1) << FRAC_BITS;

    logic                  r_fill_busy;
    logic [TABLE_BITS-1:0] r_fill_idx;
    logic [X_W-1:0]        frac_ext;
    logic [FRAC_BITS-1:0]  frac;
    logic [P_W-1:0]        phase;
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] idx;
    logic [TABLE_BITS-1:0] rd_addr;
    logic                  rd_zero;
    logic                  rd_neg;
    logic                  r_zero;
    logic                  r_neg;
    logic [E_W-1:0]        rd_data;
    logic [E_W-1:0]        entry;

    // table load sweep after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_idx  <= '0;
        end else if (r_fill_busy) begin
            r_fill_idx <= r_fill_idx + 1'b1;
            if (r_fill_idx == TABLE_BITS'(N - 1)) begin
                r_fill_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_fill_busy;

    // fractional part of x as phase, scaled to quadrant and table index
    assign frac_ext = {{FRAC_BITS{1'b0}}, i_coord};
    assign frac     = frac_ext[FRAC_BITS-1:0];

    generate
        if (FRAC_BITS >= P_W) begin : g_phase_trunc
            assign phase = frac[FRAC_BITS-1 -: P_W];
        end else begin : g_phase_widen
            assign phase = {frac, {(P_W - FRAC_BITS){1'b0}}};
        end
    endgenerate

    assign quad = phase[P_W-1 -: 2];
    assign idx  = phase[TABLE_BITS-1:0];

    // odd quadrants mirror the index, index n reads as zero
    assign rd_addr = quad[0] ? (TABLE_BITS'(0) - idx) : idx;
    assign rd_zero = quad[0] && (idx == '0);
    assign rd_neg  = quad[0] ^ quad[1];

    rfa_ram #(
        .WIDTH (E_W),
        .DEPTH (N)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (r_fill_busy),
        .i_wr_addr (r_fill_idx),
        .i_wr_data (COS_ROM[r_fill_idx]),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // flags travel with the table read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_zero <= rd_zero;
            r_neg  <= rd_neg;
        end
    end

    // one minus cosine, never negative
    assign entry = r_zero ? '0 : rd_data;
    assign o_gap = r_neg ? (ONE + G_W'(entry)) : (ONE - G_W'(entry));

endmodule

### rtl/core/rfa_accum.sv
module rfa_accum #(
    parameter int MAX_DIMS = 64,
    parameter int TERM_W   = 45
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_t_valid,
    input  logic                    i_t_last,
    input  logic [TERM_W-1:0]       i_t_term,
    input  logic [rfa_pkg::TAG_W-1:0] i_t_tag,
    input  logic                    i_out_stall,
    output logic                    o_advance,
    output logic                    o_out_valid,
    output rfa_pkg::t_out_req       o_out_req
);

    localparam int CNT_W = $clog2(MAX_DIMS + 1);
    localparam int ADD_W = (TERM_W > rfa_pkg::FIT_W ? TERM_W : rfa_pkg::FIT_W) + 1;

    logic [rfa_pkg::FIT_W-1:0] r_sum;
    logic [rfa_pkg::FIT_W-1:0] n_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic                      r_ovf;
    logic                      n_ovf;
    logic                      r_out_valid;
    logic                      n_out_valid;
    rfa_pkg::t_out_req         r_out_req;
    logic [ADD_W-1:0]          sum_wide;
    logic [rfa_pkg::FIT_W-1:0] acc_sum;
    logic [CNT_W-1:0]          acc_cnt;
    logic                      acc_ovf;
    logic                      take;
    logic                      load;

    // a last coordinate waits while the result register is full and stalled
    assign o_advance = !(r_out_valid && i_out_stall && i_t_valid && i_t_last);
    assign take      = i_t_valid && o_advance;
    assign load      = take && i_t_last;
    assign sum_wide  = ADD_W'(r_sum) + ADD_W'(i_t_term);

    // saturating accumulate, capped dimension count
    always_comb begin
        acc_sum = r_sum;
        acc_cnt = r_cnt;
        acc_ovf = r_ovf;
        if (take) begin
            if (r_cnt < CNT_W'(MAX_DIMS)) begin
                if (sum_wide > ADD_W'(rfa_pkg::SUM_MAX)) begin
                    acc_sum = rfa_pkg::SUM_MAX;
                    acc_ovf = 1'b1;
                end else begin
                    acc_sum = sum_wide[rfa_pkg::FIT_W-1:0];
                end
                acc_cnt = r_cnt + 1'b1;
            end else begin
                acc_ovf = 1'b1;
            end
        end
    end

    // clear after the last coordinate of a candidate
    always_comb begin
        n_sum       = load ? '0 : acc_sum;
        n_cnt       = load ? '0 : acc_cnt;
        n_ovf       = load ? 1'b0 : acc_ovf;
        n_out_valid = (r_out_valid && i_out_stall) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_req.fitness    <= acc_sum;
            r_out_req.result_tag <= i_t_tag;
            r_out_req.dims_used  <= rfa_pkg::DIMS_W'(acc_cnt);
            r_out_req.saturated  <= acc_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // count never passes the cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIMS))
        else $error("dimension count above cap");

    // state clears behind a last coordinate
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_sum == '0) && (r_cnt == '0) && !r_ovf)
        else $error("state not cleared after last coordinate");

    // the sum only grows along with the count
    a_sum_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum != '0) |-> (r_cnt != '0))
        else $error("nonzero sum with no coordinates");

endmodule

### rtl/core/rastrigin_fitness_accumulator.sv
// a result reaches o_out_valid through the input, term and result registers
// throughput: one coordinate per cycle, held back only during the table load or while a
//   finished result is stalled and the next last coordinate reaches the accumulator
// reset: clears sum, count and overflow flag, then loads all 2^COS_TABLE_BITS entries
//   (1024 by default) of the cosine table from constants with o_in_stall high
module rastrigin_fitness_accumulator #(
    parameter int FRAC_BITS      = 16,
    parameter int MAX_DIMS       = 64,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rfa_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rfa_pkg::t_out_req o_out_req
);

    localparam int CW     = rfa_pkg::COORD_W;
    localparam int SQ_W   = 2 * CW;
    localparam int SQR_W  = SQ_W - FRAC_BITS;
    localparam int CP_W   = FRAC_BITS + 5;
    localparam int TERM_W = (SQR_W > CP_W ? SQR_W : CP_W) + 1;

    logic                      advance;
    logic                      busy;
    logic                      in_accept;
    logic [CW-1:0]             mag;
    logic                      r_s1_valid;
    logic [CW-1:0]             r_s1_mag;
    logic [rfa_pkg::TAG_W-1:0] r_s1_tag;
    logic                      r_s1_last;
    logic [FRAC_BITS+1:0]      gap;
    logic [SQ_W-1:0]           sq;
    logic [SQ_W-1:0]           sq_rnd;
    logic [SQR_W-1:0]          sqr;
    logic [CP_W-1:0]           gap10;
    logic [TERM_W-1:0]         term;
    logic                      r_t_valid;
    logic                      r_t_last;
    logic [TERM_W-1:0]         r_t_term;
    logic [rfa_pkg::TAG_W-1:0] r_t_tag;

    assign o_in_stall = busy || !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // magnitude of the coordinate
    assign mag = i_in_req.coord_value[CW-1] ? (CW'(0) - CW'(i_in_req.coord_value))
                                            : CW'(i_in_req.coord_value);

    // cosine table read runs beside the input register
    rfa_cos_lookup #(
        .FRAC_BITS  (FRAC_BITS),
        .TABLE_BITS (COS_TABLE_BITS)
    ) u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (advance),
        .i_coord (i_in_req.coord_value),
        .o_busy  (busy),
        .o_gap   (gap)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_mag  <= mag;
            r_s1_tag  <= i_in_req.member_tag;
            r_s1_last <= i_in_req.last_coord;
        end
    end

    // rounded square plus ten times one minus cosine
    assign sq     = SQ_W'(r_s1_mag) * SQ_W'(r_s1_mag);
    assign sq_rnd = sq + (SQ_W'(1) << (FRAC_BITS - 1));
    assign sqr    = sq_rnd[SQ_W-1:FRAC_BITS];
    assign gap10  = CP_W'({gap, 3'b000}) + CP_W'({gap, 1'b0});
    assign term   = TERM_W'(sqr) + TERM_W'(gap10);

    // term register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (advance) begin
            r_t_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_t_term <= term;
            r_t_tag  <= r_s1_tag;
            r_t_last <= r_s1_last;
        end
    end

    // running sum and result register
    rfa_accum #(
        .MAX_DIMS (MAX_DIMS),
        .TERM_W   (TERM_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_t_valid   (r_t_valid),
        .i_t_last    (r_t_last),
        .i_t_term    (r_t_term),
        .i_t_tag     (r_t_tag),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_DIMS    = 64;
    localparam int COS_BITS    = 10;
    localparam int TBL_N       = 1 << COS_BITS;
    localparam int PH_W        = COS_BITS + 2;
    localparam int ITEM_GOAL   = 2000;
    localparam int RESULT_GOAL = 48;
    localparam int DRAIN_EVERY = 25;
    localparam longint ONE     = longint'(1) << FRAC_BITS;
    localparam longint SUM_CAP = (longint'(1) << rfa_pkg::FIT_W) - 1;

    // receiver back-pressure styles
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_stall_mode;

    // directed candidate: count coordinates of one value, the last one flagged
    typedef struct packed {
        logic [7:0]                         count;
        logic signed [rfa_pkg::COORD_W-1:0] coord;
        logic [rfa_pkg::TAG_W-1:0]          tag;
        logic                               typed;
        rfa_pkg::t_out_req                  res;
    } t_dir_row;

    localparam t_dir_row DIRECTED [15] = '{
        '{8'd1,  22'sd0,        16'h0000, 1'b1, '{33'd0,          16'h0000, 7'd1,  1'b0}},
        '{8'd1,  22'sd65536,    16'hFFFF, 1'b1, '{33'd65536,      16'hFFFF, 7'd1,  1'b0}},
        '{8'd1,  -22'sd65536,   16'h5A5A, 1'b1, '{33'd65536,      16'h5A5A, 7'd1,  1'b0}},
        '{8'd1,  22'sd32768,    16'h0001, 1'b1, '{33'd1327104,    16'h0001, 7'd1,  1'b0}},
        '{8'd1,  -22'sd32768,   16'h0002, 1'b1, '{33'd1327104,    16'h0002, 7'd1,  1'b0}},
        '{8'd1,  22'sd16384,    16'h0003, 1'b1, '{33'd659456,     16'h0003, 7'd1,  1'b0}},
        '{8'd1,  22'sd49152,    16'h0004, 1'b1, '{33'd692224,     16'h0004, 7'd1,  1'b0}},
        '{8'd1,  -22'sd2097152, 16'h8000, 1'b1, '{33'd67108864,   16'h8000, 7'd1,  1'b0}},
        '{8'd1,  22'sd2097151,  16'h7FFF, 1'b0, '0},
        '{8'd1,  -22'sd1,       16'h0005, 1'b0, '0},
        '{8'd1,  22'sd1,        16'h0006, 1'b0, '0},
        '{8'd3,  22'sd41943,    16'h00FF, 1'b0, '0},
        '{8'd2,  22'sd335544,   16'h0F0F, 1'b0, '0},
        '{8'd4,  -22'sd335544,  16'hF0F0, 1'b0, '0},
        // past the dimension cap, last flag on the extra coordinate
        '{8'd65, -22'sd2097152, 16'hABCD, 1'b1, '{33'd4294967296, 16'hABCD, 7'd64, 1'b1}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    rfa_pkg::t_in_req  i_in_req;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    rfa_pkg::t_out_req o_out_req;

    // mirror of the accumulator
    longint            acc_sum;
    int                acc_dims;
    bit                acc_over;
    longint            cos_quarter [0:TBL_N];
    rfa_pkg::t_out_req pending_fitness [$];

    int          items_sent   = 0;
    int          results_seen = 0;
    int          mismatches   = 0;
    int          burst_left   = 1;
    int          stall_run    = 0;
    t_stall_mode stall_mode   = STALL_NONE;

    rastrigin_fitness_accumulator #(
        .FRAC_BITS      (FRAC_BITS),
        .MAX_DIMS       (MAX_DIMS),
        .COS_TABLE_BITS (COS_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // cosine of a Q30 angle by taylor series through t^24, clamped to [0, 1]
    function automatic longint taylor_cos_q30(input longint unsigned ang);
        longint unsigned ang_sq;
        longint unsigned pw;
        longint          acc;
        int              n;
        ang_sq = (ang * ang) >> 30;
        pw     = rfa_pkg::ONE_Q30;
        acc    = longint'(rfa_pkg::ONE_Q30);
        for (n = 1; n <= 12; n++) begin
            pw = (pw * ang_sq) >> 30;
            pw = pw / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                acc = acc - longint'(pw);
            end else begin
                acc = acc + longint'(pw);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(rfa_pkg::ONE_Q30)) begin
            acc = longint'(rfa_pkg::ONE_Q30);
        end
        return acc;
    endfunction

    // add one coordinate to the mirrored sum, returns 1 when a fitness is due
    function automatic bit fold_coord(input rfa_pkg::t_in_req req,
                                      output rfa_pkg::t_out_req res);
        longint          x;
        longint          sq_round;
        logic [PH_W-1:0] phase;
        logic [COS_BITS-1:0] idx;
        longint          c;
        longint          total;
        res = '0;
        x   = longint'($signed(req.coord_value));
        if (x < 0) begin
            x = -x;
        end
        sq_round = (x * x + longint'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // phase is the fractional part, top two bits pick the quadrant
        phase = PH_W'(req.coord_value[FRAC_BITS-1:0] >> (FRAC_BITS - PH_W));
        idx   = phase[COS_BITS-1:0];
        case (phase[PH_W-1 -: 2])
            2'd0:    c = cos_quarter[idx];
            2'd1:    c = -cos_quarter[TBL_N - int'(idx)];
            2'd2:    c = -cos_quarter[idx];
            default: c = cos_quarter[TBL_N - int'(idx)];
        endcase
        if (acc_dims < MAX_DIMS) begin
            total = acc_sum + sq_round + 10 * (ONE - c);
            if (total > SUM_CAP) begin
                total    = SUM_CAP;
                acc_over = 1'b1;
            end
            acc_sum  = total;
            acc_dims = acc_dims + 1;
        end else begin
            acc_over = 1'b1;
        end
        if (!req.last_coord) begin
            return 1'b0;
        end
        res.fitness    = rfa_pkg::FIT_W'(acc_sum);
        res.result_tag = req.member_tag;
        res.dims_used  = rfa_pkg::DIMS_W'(acc_dims);
        res.saturated  = acc_over;
        acc_sum  = 0;
        acc_dims = 0;
        acc_over = 1'b0;
        return 1'b1;
    endfunction

    // coordinate mix: rastrigin domain, full range, quarter points, near the ends
    function automatic logic signed [rfa_pkg::COORD_W-1:0] draw_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 671088)) - 335544;
            4, 5, 6, 7: v = int'($urandom);
            8:          v = (int'($urandom_range(0, 255)) - 128) * 16384;
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = 2097151 - int'($urandom_range(0, 255));
                end else begin
                    v = -2097152 + int'($urandom_range(0, 255));
                end
            end
        endcase
        return rfa_pkg::COORD_W'(v);
    endfunction

    // send one coordinate request, then maybe a gap before the next burst
    task automatic push_coord(input rfa_pkg::t_in_req req, input bit typed,
                              input rfa_pkg::t_out_req typed_res);
        rfa_pkg::t_out_req got;
        i_in_req   <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (fold_coord(req, got)) begin
            pending_fitness.push_back(typed ? typed_res : got);
        end
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // hold off the sender until every pending fitness is back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_fitness.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string field, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // result side: check each accepted result, then pick the next stall
    always @(posedge i_clk) begin
        rfa_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_fitness.size() == 0) begin
                mismatches++;
                $display("%0t: result with none pending, expected nothing actual fitness %0d",
                         $time, o_out_req.fitness);
            end else begin
                want = pending_fitness.pop_front();
                report_field("fitness", want.fitness, o_out_req.fitness);
                report_field("result_tag", want.result_tag, o_out_req.result_tag);
                report_field("dims_used", want.dims_used, o_out_req.dims_used);
                report_field("saturated", want.saturated, o_out_req.saturated);
            end
        end
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_run  = $urandom_range(20, 150);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= !i_out_stall;
        endcase
    end

    // stimulus
    initial begin
        int                        row;
        int                        k;
        int                        dims;
        int                        pick;
        int                        cand;
        logic [rfa_pkg::TAG_W-1:0] tag;
        rfa_pkg::t_in_req          req;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;

        // quarter-wave table, Q30 rounded half up to the fraction width
        for (k = 0; k < TBL_N; k++) begin
            cos_quarter[k] = (taylor_cos_q30((rfa_pkg::HALF_PI_Q30 * 64'(k)) >> COS_BITS)
                              + longint'(1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
        end
        cos_quarter[TBL_N] = 0;
        acc_sum  = 0;
        acc_dims = 0;
        acc_over = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed candidates
        for (row = 0; row < $size(DIRECTED); row++) begin
            for (k = 0; k < int'(DIRECTED[row].count); k++) begin
                req.coord_value = DIRECTED[row].coord;
                req.member_tag  = DIRECTED[row].tag;
                req.last_coord  = (k == int'(DIRECTED[row].count) - 1);
                push_coord(req, DIRECTED[row].typed, DIRECTED[row].res);
            end
        end
        wait_results_drained();

        // random candidates, mostly short, some past the cap
        cand = 0;
        while (items_sent < ITEM_GOAL || results_seen < RESULT_GOAL) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                dims = $urandom_range(1, 6);
            end else if (pick < 9) begin
                dims = $urandom_range(7, MAX_DIMS);
            end else begin
                dims = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 8);
            end
            tag = rfa_pkg::TAG_W'($urandom);
            for (k = 0; k < dims; k++) begin
                req.coord_value = draw_coord();
                req.member_tag  = ($urandom_range(0, 7) == 0) ? rfa_pkg::TAG_W'($urandom) : tag;
                req.last_coord  = (k == dims - 1);
                push_coord(req, 1'b0, '0);
            end
            cand++;
            if (cand % DRAIN_EVERY == 0) begin
                wait_results_drained();
            end
        end

        // let the pipeline settle, then report
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
